@@ sv/lss_pkg.sv @@
// lss_pkg: request and status codes for the bounded stack with reverse and sort
// shared by lifo_stack_with_sort; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lss_pkg;

    // request codes
    localparam logic [2:0] OP_PUSH    = 3'd0;
    localparam logic [2:0] OP_POP     = 3'd1;
    localparam logic [2:0] OP_PEEK    = 3'd2;
    localparam logic [2:0] OP_REVERSE = 3'd3;
    localparam logic [2:0] OP_SORT    = 3'd4;

    // status codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_UNDER = 2'd1;
    localparam logic [1:0] ERR_OVER  = 2'd2;

    // fixed widths of the result fields
    localparam int RESULT_W = 32;
    localparam int DEPTH_W  = 5;

endpackage : lss_pkg

`default_nettype wire

@@ sv/lss_ram.sv @@
// lss_ram: generic synchronous RAM, one write port and two registered read ports
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] ra_addr,
    output logic      [WIDTH-1:0]         ra_data,
    input  wire logic [$clog2(DEPTH)-1:0] rb_addr,
    output logic      [WIDTH-1:0]         rb_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule : lss_ram

`default_nettype wire

@@ sv/lifo_stack_with_sort.sv @@
// lifo_stack_with_sort: bounded stack of signed words with push, pop, peek,
// in-place reverse and insertion sort; depends on lss_pkg and lss_ram
//
//   channel   handshake             payload
//   request   start / busy          opcode, push_value
//   result    done (one cycle)      result_value, error_code, is_empty, depth
//
// push, no-op and underflow requests raise done in the cycle after they are
// accepted; pop and peek wait in ST_POP for the registered stack RAM read.
// reverse reads a pair, writes the lower slot, then writes the upper slot and
// fetches the next pair, for floor(n/2) pairs of n entries.
// sort inserts each entry in turn, one shift per cycle through the single RAM
// write port; a stack of fewer than two entries finishes as a no-op.
// reset clears the entry count and sequencer registers; the RAM needs no clearing pass.
// busy is high while a request runs; done cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module lifo_stack_with_sort
    import lss_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [2:0]                 opcode,
    input  wire logic signed [RESULT_W-1:0] push_value,
    output logic                            done,
    output logic signed [RESULT_W-1:0]      result_value,
    output logic [1:0]                      error_code,
    output logic                            is_empty,
    output logic [DEPTH_W-1:0]              depth
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_REV_SWAP,
        ST_REV_BACK,
        ST_SORT_LOAD,
        ST_SORT_CMP,
        ST_SORT_PUT
    } state_t;

    state_t                       state_reg;
    logic [CW-1:0]                count_reg;
    logic                         pop_reg;
    logic [AW-1:0]                lo_reg;
    logic [AW-1:0]                hi_reg;
    logic [AW-1:0]                i_reg;
    logic [AW-1:0]                j_reg;
    logic [DATA_WIDTH-1:0]        v_reg;
    logic [DATA_WIDTH-1:0]        hold_reg;
    logic                         done_reg;
    logic signed [RESULT_W-1:0]   result_value_reg;
    logic [1:0]                   error_code_reg;

    logic                         accept;
    logic                         full;
    logic [AW-1:0]                top_addr;
    logic [DATA_WIDTH-1:0]        push_word;
    logic                         shift_up;
    logic                         more_sort;
    logic                         more_rev;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [DATA_WIDTH-1:0]        ram_wdata;
    logic [AW-1:0]                ram_ra_addr;
    logic [DATA_WIDTH-1:0]        ram_ra_data;
    logic [AW-1:0]                ram_rb_addr;
    logic [DATA_WIDTH-1:0]        ram_rb_data;

    lss_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .ra_addr (ram_ra_addr),
        .ra_data (ram_ra_data),
        .rb_addr (ram_rb_addr),
        .rb_data (ram_rb_data)
    );

    // request status and helpers
    assign accept    = start && (state_reg == ST_IDLE);
    assign full      = (count_reg == CW'(DEPTH));
    assign top_addr  = AW'(count_reg - CW'(1));
    assign push_word = DATA_WIDTH'(push_value);
    assign shift_up  = $signed(ram_ra_data) > $signed(v_reg);
    assign more_sort = (CW'(i_reg) + CW'(1)) < count_reg;
    assign more_rev  = (CW'(lo_reg) + CW'(2)) < CW'(hi_reg);

    // RAM port control
    always_comb
    begin
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_ra_addr = '0;
        ram_rb_addr = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (opcode)
                        OP_PUSH:
                        begin
                            ram_we    = !full;
                            ram_waddr = count_reg[AW-1:0];
                            ram_wdata = push_word;
                        end
                        OP_POP, OP_PEEK:
                        begin
                            ram_ra_addr = top_addr;
                        end
                        OP_REVERSE:
                        begin
                            ram_ra_addr = '0;
                            ram_rb_addr = top_addr;
                        end
                        OP_SORT:
                        begin
                            ram_ra_addr = AW'(1);
                        end
                        default:
                        begin
                            ram_we = 1'b0;
                        end
                    endcase
                end
            end
            ST_REV_SWAP:
            begin
                // lower slot takes the upper word
                ram_we    = 1'b1;
                ram_waddr = lo_reg;
                ram_wdata = ram_rb_data;
            end
            ST_REV_BACK:
            begin
                // upper slot takes the saved lower word, fetch next pair
                ram_we      = 1'b1;
                ram_waddr   = hi_reg;
                ram_wdata   = hold_reg;
                ram_ra_addr = lo_reg + AW'(1);
                ram_rb_addr = hi_reg - AW'(1);
            end
            ST_SORT_LOAD:
            begin
                ram_ra_addr = i_reg - AW'(1);
            end
            ST_SORT_CMP:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                if (shift_up)
                begin
                    ram_wdata   = ram_ra_data;
                    ram_ra_addr = j_reg - AW'(2);
                end
                else
                begin
                    ram_wdata   = v_reg;
                    ram_ra_addr = i_reg + AW'(1);
                end
            end
            ST_SORT_PUT:
            begin
                ram_we      = 1'b1;
                ram_waddr   = '0;
                ram_wdata   = v_reg;
                ram_ra_addr = i_reg + AW'(1);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // sequencer state and result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            pop_reg          <= 1'b0;
            lo_reg           <= '0;
            hi_reg           <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            v_reg            <= '0;
            hold_reg         <= '0;
            done_reg         <= 1'b0;
            result_value_reg <= '0;
            error_code_reg   <= ERR_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        result_value_reg <= '0;
                        error_code_reg   <= ERR_OK;
                        case (opcode)
                            OP_PUSH:
                            begin
                                done_reg <= 1'b1;
                                if (full)
                                begin
                                    error_code_reg <= ERR_OVER;
                                end
                                else
                                begin
                                    count_reg <= count_reg + CW'(1);
                                end
                            end
                            OP_POP, OP_PEEK:
                            begin
                                if (count_reg == '0)
                                begin
                                    done_reg       <= 1'b1;
                                    error_code_reg <= ERR_UNDER;
                                end
                                else
                                begin
                                    pop_reg   <= (opcode == OP_POP);
                                    state_reg <= ST_POP;
                                end
                            end
                            OP_REVERSE:
                            begin
                                if (count_reg < CW'(2))
                                begin
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    lo_reg    <= '0;
                                    hi_reg    <= top_addr;
                                    state_reg <= ST_REV_SWAP;
                                end
                            end
                            OP_SORT:
                            begin
                                if (count_reg < CW'(2))
                                begin
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    i_reg     <= AW'(1);
                                    state_reg <= ST_SORT_LOAD;
                                end
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_POP:
                begin
                    // top word arrives from the RAM
                    result_value_reg <= RESULT_W'($signed(ram_ra_data));
                    done_reg         <= 1'b1;
                    if (pop_reg)
                    begin
                        count_reg <= count_reg - CW'(1);
                    end
                    state_reg <= ST_IDLE;
                end
                ST_REV_SWAP:
                begin
                    hold_reg  <= ram_ra_data;
                    state_reg <= ST_REV_BACK;
                end
                ST_REV_BACK:
                begin
                    lo_reg <= lo_reg + AW'(1);
                    hi_reg <= hi_reg - AW'(1);
                    if (more_rev)
                    begin
                        state_reg <= ST_REV_SWAP;
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SORT_LOAD:
                begin
                    // word being inserted
                    v_reg     <= ram_ra_data;
                    j_reg     <= i_reg;
                    state_reg <= ST_SORT_CMP;
                end
                ST_SORT_CMP:
                begin
                    if (shift_up)
                    begin
                        j_reg <= j_reg - AW'(1);
                        if (j_reg == AW'(1))
                        begin
                            state_reg <= ST_SORT_PUT;
                        end
                    end
                    else
                    begin
                        i_reg <= i_reg + AW'(1);
                        if (more_sort)
                        begin
                            state_reg <= ST_SORT_LOAD;
                        end
                        else
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_SORT_PUT:
                begin
                    i_reg <= i_reg + AW'(1);
                    if (more_sort)
                    begin
                        state_reg <= ST_SORT_LOAD;
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result ports
    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign result_value = result_value_reg;
    assign error_code   = error_code_reg;
    assign is_empty     = (count_reg == '0);
    assign depth        = DEPTH_W'(count_reg);

endmodule : lifo_stack_with_sort

`default_nettype wire
